@@ src/ola_pkg.sv @@
// ola_pkg: shared types and codes for the obstacle lane assigner
// no dependencies; used by ola_cfg and obstacle_lane_assigner_top
package ola_pkg;

  typedef enum logic [2:0] {
    REG_LEFT_C0  = 3'd0,
    REG_LEFT_C1  = 3'd1,
    REG_LEFT_C2  = 3'd2,
    REG_LEFT_C3  = 3'd3,
    REG_RIGHT_C0 = 3'd4,
    REG_RIGHT_C1 = 3'd5,
    REG_RIGHT_C2 = 3'd6,
    REG_RIGHT_C3 = 3'd7
  } reg_idx_e;

  // two's complement lane codes
  typedef enum logic [2:0] {
    LANE_CUR       = 3'b000,
    LANE_CUR_RIGHT = 3'b001,
    LANE_RIGHT     = 3'b010,
    LANE_ALL       = 3'b011,
    LANE_NONE      = 3'b101,
    LANE_LEFT      = 3'b110,
    LANE_LEFT_CUR  = 3'b111
  } lane_code_e;

  // left plus right coefficient sums and lane width
  typedef struct packed {
    logic signed [32:0] c0s;
    logic signed [32:0] c1s;
    logic signed [32:0] c2s;
    logic signed [32:0] c3s;
    logic [30:0]        lane_w;
  } coef_t;

  localparam logic [30:0] LANE_W_MAX = 31'h7FFF_FFFF;

endpackage

@@ src/ola_cfg.sv @@
// ola_cfg: apb register file for the lane boundary coefficients
// derives the coefficient sums and lane width; depends on ola_pkg
module ola_cfg #(
  parameter int unsigned POS_FRAC_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output ola_pkg::coef_t coef_o
);
  import ola_pkg::*;

  localparam logic [31:0] C0_RST     = 32'd7 << (POS_FRAC_BITS - 2);
  localparam logic [30:0] LANE_W_RST = 31'd7 << (POS_FRAC_BITS - 1);

  logic [31:0]        cfg_q [8];
  logic               wr_en;
  coef_t              coef_d, coef_q;
  logic signed [32:0] diff;
  logic [32:0]        mag;

  function automatic logic signed [32:0] sx(input logic [31:0] a);
    return {a[31], a};
  endfunction

  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign prdata = cfg_q[paddr[4:2]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        if (i == int'(REG_LEFT_C0)) begin
          cfg_q[i] <= ~C0_RST + 32'd1;
        end else if (i == int'(REG_RIGHT_C0)) begin
          cfg_q[i] <= C0_RST;
        end else begin
          cfg_q[i] <= '0;
        end
      end
    end else if (wr_en) begin
      cfg_q[paddr[4:2]] <= pwdata;
    end
  end

  always_comb begin
    coef_d.c0s = sx(cfg_q[REG_LEFT_C0]) + sx(cfg_q[REG_RIGHT_C0]);
    coef_d.c1s = sx(cfg_q[REG_LEFT_C1]) + sx(cfg_q[REG_RIGHT_C1]);
    coef_d.c2s = sx(cfg_q[REG_LEFT_C2]) + sx(cfg_q[REG_RIGHT_C2]);
    coef_d.c3s = sx(cfg_q[REG_LEFT_C3]) + sx(cfg_q[REG_RIGHT_C3]);
    diff = sx(cfg_q[REG_RIGHT_C0]) - sx(cfg_q[REG_LEFT_C0]);
    mag  = diff[32] ? 33'(-diff) : 33'(diff);
    coef_d.lane_w = (mag[32:31] != 2'b00) ? LANE_W_MAX : mag[30:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '{c0s: '0, c1s: '0, c2s: '0, c3s: '0, lane_w: LANE_W_RST};
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

@@ src/obstacle_lane_assigner_top.sv @@
// obstacle_lane_assigner_top: sorts obstacles into lane codes against cubic boundaries
// uses ola_pkg and ola_cfg
// throughput: one request per cycle while out_stall_i is low, set by the nine-stage multiply and accumulate pipeline
// reset: pipeline empty, boundaries at -1.75 m and +1.75 m with no curvature
module obstacle_lane_assigner_top #(
  parameter int unsigned POS_FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] obstacle_long_i,
  input  logic signed [31:0] obstacle_lat_i,
  input  logic [23:0]        obstacle_width_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [2:0]  lane_code_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ola_pkg::*;

  localparam int unsigned F     = POS_FRAC_BITS;
  localparam int unsigned SH_U  = 48 + 2 * F;
  localparam int unsigned SH_C1 = 20 + 2 * F;
  localparam int unsigned SH_C2 = 8 + F;
  localparam int unsigned SR    = 49 + 2 * F;
  localparam int unsigned AW    = (2 * F + 88 > 130) ? 2 * F + 88 : 130;
  localparam int unsigned RW    = AW - SR;
  localparam int unsigned NS    = 9;
  localparam logic signed [35:0] MARGIN = 36'sd1 <<< F;

  coef_t coef;

  logic [NS-1:0] v_q;
  logic [NS-1:0] v_in;
  logic [NS:0]   rdy;
  logic          in_acc, out_acc;

  logic [23:0] w_q   [0:NS-2];
  logic        org_q [0:NS-2];

  logic signed [31:0]   z_s0_q, x_s0_q;
  logic signed [31:0]   z_s1_q;
  logic signed [63:0]   zsq_q;
  logic signed [64:0]   c1z_q;
  logic signed [33:0]   u_q;
  logic signed [63:0]   pzh_q;
  logic signed [64:0]   pzl_q;
  logic signed [64:0]   pc2h_q;
  logic signed [65:0]   pc2l_q;
  logic signed [AW-1:0] p1_q, p1b_q;
  logic signed [95:0]   zcb_q;
  logic signed [96:0]   c2z2_q;
  logic signed [65:0]   pc3l_q, pc3m_q;
  logic signed [64:0]   pc3h_q;
  logic signed [AW-1:0] p2_q, p2b_q;
  logic signed [128:0]  c3z3_q;
  logic signed [AW-1:0] acc_q;
  logic signed [32:0]   f2_q;
  lane_code_e           lane_q;

  logic [RW-1:0]      sh;
  logic [31:0]        fsat;
  logic signed [35:0] f2e, we, lw, lw3, hi, lo;
  lane_code_e         code;

  ola_cfg #(
    .POS_FRAC_BITS(POS_FRAC_BITS)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .coef_o (coef)
  );

  // stage advance chain
  always_comb begin
    rdy[NS] = !out_stall_i;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = v_q[NS-1];
  assign in_acc      = in_valid_i && rdy[0];
  assign out_acc     = v_q[NS-1] && !out_stall_i;
  assign v_in        = {v_q[NS-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  // width and origin flag ride along
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      w_q[0]   <= obstacle_width_i;
      org_q[0] <= (obstacle_long_i == 32'sd0) && (obstacle_lat_i == 32'sd0);
    end
    for (int k = 1; k < NS - 1; k++) begin
      if (rdy[k]) begin
        w_q[k]   <= w_q[k-1];
        org_q[k] <= org_q[k-1];
      end
    end
  end

  // s0: capture
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      z_s0_q <= obstacle_long_i;
      x_s0_q <= obstacle_lat_i;
    end
  end

  // s1: z squared, heading term, offset base
  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      z_s1_q <= z_s0_q;
      zsq_q  <= z_s0_q * z_s0_q;
      c1z_q  <= coef.c1s * z_s0_q;
      u_q    <= $signed({x_s0_q[31], x_s0_q, 1'b0}) - 34'(coef.c0s);
    end
  end

  // s2: partial products for z cubed and curvature term
  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      pzh_q  <= $signed(zsq_q[63:32]) * z_s1_q;
      pzl_q  <= $signed({1'b0, zsq_q[31:0]}) * z_s1_q;
      pc2h_q <= coef.c2s * $signed(zsq_q[63:32]);
      pc2l_q <= coef.c2s * $signed({1'b0, zsq_q[31:0]});
      p1_q   <= (AW'(u_q) <<< SH_U) - (AW'(c1z_q) <<< SH_C1);
    end
  end

  // s3: combine partial products
  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      zcb_q  <= {pzh_q, 32'd0} + {{31{pzl_q[64]}}, pzl_q};
      c2z2_q <= {pc2h_q, 32'd0} + {{31{pc2l_q[65]}}, pc2l_q};
      p1b_q  <= p1_q;
    end
  end

  // s4: curvature rate partial products
  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      pc3l_q <= coef.c3s * $signed({1'b0, zcb_q[31:0]});
      pc3m_q <= coef.c3s * $signed({1'b0, zcb_q[63:32]});
      pc3h_q <= coef.c3s * $signed(zcb_q[95:64]);
      p2_q   <= p1b_q - (AW'(c2z2_q) <<< SH_C2);
    end
  end

  // s5: curvature rate term
  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      c3z3_q <= {pc3h_q, 64'd0} + {{31{pc3m_q[65]}}, pc3m_q, 32'd0}
              + {{63{pc3l_q[65]}}, pc3l_q};
      p2b_q  <= p2_q;
    end
  end

  // s6: twice the offset at full precision
  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      acc_q <= p2b_q - AW'(c3z3_q);
    end
  end

  // s7: floor and saturate offset
  always_comb begin
    sh = acc_q[AW-1:SR];
    if ((&sh[RW-1:31]) || !(|sh[RW-1:31])) begin
      fsat = sh[31:0];
    end else begin
      fsat = sh[RW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[7]) begin
      f2_q <= $signed({fsat, 1'b0});
    end
  end

  // s8: lane decision
  always_comb begin
    f2e  = 36'(f2_q);
    we   = $signed({12'd0, w_q[NS-2]});
    lw   = $signed({5'd0, coef.lane_w});
    lw3  = lw + (lw <<< 1);
    hi   = f2e + we;
    lo   = f2e - we;
    code = LANE_NONE;
    if (hi < -lw3 || lo > lw3) begin
      code = LANE_NONE;
    end else if (f2e >= -lw && f2e <= lw && !org_q[NS-2]) begin
      code = LANE_CUR;
      if (hi > lw + MARGIN) begin
        code = LANE_CUR_RIGHT;
        if (lo < -lw - MARGIN) begin
          code = LANE_ALL;
        end
      end
    end else if (f2e >= -lw3 && f2e <= -lw) begin
      code = LANE_LEFT;
      if (hi > -lw + MARGIN) begin
        code = LANE_LEFT_CUR;
        if (hi > lw + MARGIN) begin
          code = LANE_ALL;
        end
      end
    end else if (f2e >= lw && f2e <= lw3) begin
      code = LANE_RIGHT;
      if (lo < lw - MARGIN) begin
        code = LANE_CUR_RIGHT;
        if (lo < -lw - MARGIN) begin
          code = LANE_ALL;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[8]) begin
      lane_q <= code;
    end
  end

  assign lane_code_o = $signed(lane_q);

  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> $countones(v_q) ==
      $past($countones(v_q)) + $past(in_acc) - $past(out_acc))
    else $error("pipeline occupancy does not match requests in and out");

  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> (!(&v_q) || !out_stall_i))
    else $error("request taken with a full stalled pipeline");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(v_q[NS-2]))
    else $error("result appeared without a request in the previous stage");

endmodule
